[rtl/core/pbo_pkg.sv]
// shared constants, types and the quarter-wave sine table of the polyblep oscillator
package pbo_pkg;

    localparam int PHASE_BITS  = 24;
    localparam int SINE_DEPTH  = 256;
    localparam int SINE_AW     = $clog2(SINE_DEPTH);
    localparam int SINE_IDX_W  = SINE_AW + 1;
    localparam int SINE_VAL_W  = 17;

    localparam int FM_W        = 25;
    localparam int DT_W        = 23;
    localparam int LEVEL_W     = 16;
    localparam int WAVE_W      = 2;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 23;

    localparam int W_W         = 18;
    localparam int QUO_W       = 17;
    localparam int MAG_W       = 16;
    localparam int MUL_A_W     = 18;
    localparam int MUL_P_W     = MUL_A_W + W_W;
    localparam int EFF_W       = 26;

    localparam logic [DT_W-1:0] DT_LIMIT = DT_W'((9 * (64'd1 << PHASE_BITS)) / 20);

    localparam logic [CFG_IDX_W-1:0] REG_BASE_INCREMENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SELECT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLEP_ENABLE    = 2'd3;

    localparam logic [WAVE_W-1:0] SHAPE_SINE  = 2'd0;
    localparam logic [WAVE_W-1:0] SHAPE_RAMP  = 2'd1;
    localparam logic [WAVE_W-1:0] SHAPE_PULSE = 2'd2;
    localparam logic [WAVE_W-1:0] SHAPE_TRI   = 2'd3;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // reciprocals for the series divisors (2n)(2n+1), rounded up
    localparam int     TAYLOR_SHIFT   = 40;
    localparam longint TAYLOR_RECIP_1 = ((longint'(1) << TAYLOR_SHIFT) + 5) / 6;
    localparam longint TAYLOR_RECIP_2 = ((longint'(1) << TAYLOR_SHIFT) + 19) / 20;
    localparam longint TAYLOR_RECIP_3 = ((longint'(1) << TAYLOR_SHIFT) + 41) / 42;
    localparam longint TAYLOR_RECIP_4 = ((longint'(1) << TAYLOR_SHIFT) + 71) / 72;
    localparam longint TAYLOR_RECIP_5 = ((longint'(1) << TAYLOR_SHIFT) + 109) / 110;
    localparam longint TAYLOR_RECIP_6 = ((longint'(1) << TAYLOR_SHIFT) + 155) / 156;
    localparam longint TAYLOR_RECIP_7 = ((longint'(1) << TAYLOR_SHIFT) + 209) / 210;

    typedef logic [SINE_VAL_W-1:0] sine_rom_t [0:SINE_DEPTH];

    // exact floor of a nonnegative series term below 2^32 over (2n)(2n+1)
    function automatic longint taylor_div(input longint term, input int n);
        longint      recip;
        logic [79:0] prod;
        unique case (n)
            1:       recip = TAYLOR_RECIP_1;
            2:       recip = TAYLOR_RECIP_2;
            3:       recip = TAYLOR_RECIP_3;
            4:       recip = TAYLOR_RECIP_4;
            5:       recip = TAYLOR_RECIP_5;
            6:       recip = TAYLOR_RECIP_6;
            default: recip = TAYLOR_RECIP_7;
        endcase
        prod = 80'(term) * 80'(recip);
        return longint'(prod >> TAYLOR_SHIFT);
    endfunction

    // sin(pi/2 * k / depth) * 32768 from a q30 taylor series, rounded half up
    function automatic sine_rom_t sine_rom_build();
        sine_rom_t rom;
        longint    x;
        longint    term;
        longint    total;
        for (int k = 0; k <= SINE_DEPTH; k++)
        begin
            x     = (HALF_PI_Q30 * longint'(k)) >>> SINE_AW;
            term  = x;
            total = x;
            for (int n = 1; n <= 7; n++)
            begin
                term = (term * x) >>> 30;
                term = (term * x) >>> 30;
                term = taylor_div(term, n);
                if ((n % 2) == 1)
                    total = total - term;
                else
                    total = total + term;
            end
            if (total < 0)
                total = 0;
            rom[k] = SINE_VAL_W'((total + 16384) >>> 15);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = sine_rom_build();

endpackage

[rtl/core/polyblep_oscillator_unit.sv]
// polyblep oscillator: sine, saw, square and triangle with optional polyblep correction
// Each accepted beat carries one frequency-modulation offset and yields one Q1.15 sample.
// The phase step is base_increment plus the offset, clamped to 0..0.45 of the sample rate.
// Sine, triangle and uncorrected waves pass S_INC, S_MUL and S_OUT after accept; with
// correction a saw adds S_SETUP and up to one polyblep term, a square up to two: every
// active polyblep term runs a 17-step restoring divider (one quotient bit per cycle) and
// one squaring on the shared 18x18 multiplier, which also forms the final level product.
// Input is taken only while the sequencer is idle, the cycle after a result is posted; a
// finished sample waits in the output register; the next holds in its last step until free.
module polyblep_oscillator_unit
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [pbo_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [pbo_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [pbo_pkg::FM_W-1:0]         fm_increment,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [pbo_pkg::SAMPLE_W-1:0]     sample
);
    import pbo_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INC   = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SQ    = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [PHASE_BITS:0] FULL_TURN = (PHASE_BITS+1)'(1) << PHASE_BITS;

    logic [2:0]                 state_reg, state_next;
    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic [DT_W-1:0]            base_reg;
    logic [LEVEL_W-1:0]         level_reg;
    logic [WAVE_W-1:0]          wave_reg;
    logic                       blep_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       pass_reg, pass_next;
    logic [4:0]                 cnt_reg, cnt_next;

    logic signed [FM_W-1:0]     fm_reg, fm_next;
    logic [DT_W-1:0]            dt_reg, dt_next;
    logic signed [W_W-1:0]      w_reg, w_next;
    logic [DT_W-1:0]            rem_reg, rem_next;
    logic [QUO_W-1:0]           quo_reg, quo_next;
    logic                       neg_reg, neg_next;
    logic signed [MUL_P_W-1:0]  prod_reg, prod_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;

    logic signed [EFF_W-1:0]    eff;
    logic [15:0]                p16;
    logic signed [W_W-1:0]      saw_w;
    logic signed [W_W-1:0]      tri_d;
    logic signed [W_W-1:0]      tri_w;
    logic signed [W_W-1:0]      sq_w;
    logic signed [W_W-1:0]      sine_w;
    logic [1:0]                 quad;
    logic [SINE_AW-1:0]         sine_i;
    logic [SINE_IDX_W-1:0]      sine_idx;
    logic [SINE_VAL_W-1:0]      sine_val;
    logic signed [W_W-1:0]      base_w;
    logic                       blep_on;

    logic [PHASE_BITS-1:0]      t_sel;
    logic [PHASE_BITS:0]        t_sum;
    logic                       t_lt;
    logic                       t_hi;
    logic [DT_W:0]              rem_shift;
    logic                       rem_ge;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [W_W-1:0]      mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    logic [MAG_W-1:0]           blep_mag;
    logic signed [W_W-1:0]      blep_val;
    logic                       blep_sub;

    logic signed [MUL_P_W:0]    rnd;
    logic signed [MUL_P_W-15:0] res;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // waveform at the current phase
    assign eff    = EFF_W'($signed({3'b000, base_reg})) + EFF_W'(fm_reg);
    assign p16    = phase_reg[PHASE_BITS-1 -: 16];
    assign saw_w  = W_W'($signed({1'b0, p16})) - W_W'(32768);
    assign tri_d  = (saw_w < 0) ? -saw_w : saw_w;
    assign tri_w  = W_W'(32768) - (tri_d <<< 1);
    assign sq_w   = phase_reg[PHASE_BITS-1] ? -W_W'(32768) : W_W'(32768);
    assign quad   = phase_reg[PHASE_BITS-1 -: 2];
    assign sine_i = phase_reg[PHASE_BITS-3 -: SINE_AW];
    assign sine_idx = quad[0] ? (SINE_IDX_W'(SINE_DEPTH) - {1'b0, sine_i}) : {1'b0, sine_i};
    assign sine_val = SINE_ROM[sine_idx];
    assign sine_w   = quad[1] ? -W_W'($signed({1'b0, sine_val}))
                              : W_W'($signed({1'b0, sine_val}));
    assign blep_on  = blep_reg && ((wave_reg == SHAPE_RAMP) || (wave_reg == SHAPE_PULSE));

    always_comb
    begin
        unique case (wave_reg)
            SHAPE_RAMP:  base_w = saw_w;
            SHAPE_PULSE: base_w = sq_w;
            SHAPE_TRI:   base_w = tri_w;
            default:     base_w = sine_w;
        endcase
    end

    // polyblep region test
    assign t_sel = pass_reg ? {~phase_reg[PHASE_BITS-1], phase_reg[PHASE_BITS-2:0]} : phase_reg;
    assign t_lt  = t_sel < PHASE_BITS'(dt_reg);
    assign t_sum = {1'b0, t_sel} + (PHASE_BITS+1)'(dt_reg);
    assign t_hi  = t_sum > FULL_TURN;

    // restoring divider step, the first step takes the integer quotient bit
    assign rem_shift = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, dt_reg};

    // shared multiplier
    always_comb
    begin
        if (state_reg == S_SQ)
        begin
            mul_a = MUL_A_W'($signed({1'b0, quo_reg}));
            mul_b = W_W'($signed({1'b0, quo_reg}));
        end
        else
        begin
            mul_a = MUL_A_W'($signed({1'b0, level_reg}));
            mul_b = w_reg;
        end
    end
    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    assign blep_mag = mul_p[32:17];
    assign blep_val = neg_reg ? -W_W'($signed({1'b0, blep_mag}))
                              : W_W'($signed({1'b0, blep_mag}));
    assign blep_sub = (wave_reg == SHAPE_RAMP) || pass_reg;

    // round half up and saturate
    assign rnd = (MUL_P_W+1)'(prod_reg) + (MUL_P_W+1)'(16384);
    assign res = rnd[MUL_P_W:15];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        pass_next      = pass_reg;
        cnt_next       = cnt_reg;
        fm_next        = fm_reg;
        dt_next        = dt_reg;
        w_next         = w_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        sample_next    = sample_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    fm_next    = fm_increment;
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                priority if (eff < 0)
                    dt_next = '0;
                else if (eff > EFF_W'($signed({3'b000, DT_LIMIT})))
                    dt_next = DT_LIMIT;
                else
                    dt_next = eff[DT_W-1:0];
                w_next     = base_w;
                pass_next  = 1'b0;
                state_next = blep_on ? S_SETUP : S_MUL;
            end
            S_SETUP:
            begin
                cnt_next = '0;
                quo_next = '0;
                priority if (dt_reg != '0 && t_lt)
                begin
                    rem_next   = DT_W'(PHASE_BITS'(dt_reg) - t_sel);
                    neg_next   = 1'b1;
                    state_next = S_DIV;
                end
                else if (dt_reg != '0 && t_hi)
                begin
                    rem_next   = t_sum[DT_W-1:0];
                    neg_next   = 1'b0;
                    state_next = S_DIV;
                end
                else if (wave_reg == SHAPE_PULSE && !pass_reg)
                    pass_next = 1'b1;
                else
                    state_next = S_MUL;
            end
            S_DIV:
            begin
                if (rem_ge)
                    rem_next = DT_W'(rem_shift - {1'b0, dt_reg});
                else
                    rem_next = rem_shift[DT_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], rem_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                    state_next = S_SQ;
            end
            S_SQ:
            begin
                w_next = blep_sub ? (w_reg - blep_val) : (w_reg + blep_val);
                if (wave_reg == SHAPE_PULSE && !pass_reg)
                begin
                    pass_next  = 1'b1;
                    state_next = S_SETUP;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    priority if (res > (MUL_P_W-14)'(32767))
                        sample_next = 16'sh7fff;
                    else if (res < -(MUL_P_W-14)'(32768))
                        sample_next = -16'sh8000;
                    else
                        sample_next = res[SAMPLE_W-1:0];
                    out_valid_next = 1'b1;
                    phase_next     = phase_reg + PHASE_BITS'(dt_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            pass_reg      <= 1'b0;
            cnt_reg       <= '0;
            base_reg      <= '0;
            level_reg     <= '0;
            wave_reg      <= SHAPE_SINE;
            blep_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            pass_reg      <= pass_next;
            cnt_reg       <= cnt_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_BASE_INCREMENT: base_reg  <= cfg_data[DT_W-1:0];
                    REG_LEVEL:          level_reg <= cfg_data[LEVEL_W-1:0];
                    REG_WAVE_SELECT:    wave_reg  <= cfg_data[WAVE_W-1:0];
                    REG_BLEP_ENABLE:    blep_reg  <= cfg_data[0];
                    default:            blep_reg  <= blep_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fm_reg     <= fm_next;
        dt_reg     <= dt_next;
        w_reg      <= w_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        sample_reg <= sample_next;
    end

endmodule
